FILE: rtl/ucsr_pkg.sv
// Shared types and constants for the undirected CSR builder.
package ucsr_pkg;

  localparam int VW = 10;
  localparam int EW = 12;
  localparam int AW = 13;
  localparam int PW = 14;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES = 4096;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_RDPTR = 2'd2,
    CMD_RDADJ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_VERTEX   = 2'd1,
    ST_FULL     = 2'd2,
    ST_INDEX    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]    command;
    logic [VW-1:0] src_vertex;
    logic [VW-1:0] dst_vertex;
    logic [AW-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [PW-1:0] pointer_value;
    logic [VW-1:0] entry_src;
    logic [VW-1:0] entry_dst;
    logic [VW:0]   vertex_count;
    logic [PW-1:0] entry_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch item and start its op
    logic clr_deg;     // clear pass over degree memory
    logic scan;        // prefix-sum step
    logic scat;        // scatter step (phase in sub)
    logic sub;         // 0: src half, 1: dst half
    logic finish;      // mark built, emit result
    logic respond;     // emit result of read/add
    logic [VW-1:0] vaddr;
    logic [EW-1:0] eaddr;
  } ctl_t;

  typedef struct packed {
    logic [EW:0]   edges;
    logic [VW:0]   nverts;
  } sts_t;

endpackage

FILE: rtl/ucsr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module ucsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/ucsr_dp.sv
// Datapath: edge, degree, pointer, fill and adjacency memories.
module ucsr_dp import ucsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_t      ctl,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);
  in_item_t itm_r;
  logic [EW:0] edges_r;
  logic [VW-1:0] hi_r;
  logic built_r;
  logic [1:0] rsp_r;
  logic [PW-1:0] run_r;
  logic [1:0] rd_cmd_r;
  logic [1:0] st_r;
  logic [PW-1:0] endptr_r;
  logic [VW:0] nv;

  assign nv = (edges_r == '0) ? '0 : {1'b0, hi_r} + 1'b1;
  assign sts.edges = edges_r;
  assign sts.nverts = nv;

  // edge memory
  logic e_we;
  logic [2*VW-1:0] e_rd;
  assign e_we = ctl.accept && in_item.command == CMD_ADD
             && edges_r < (EW+1)'(MAX_EDGES);
  ucsr_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(e_we), .waddr(edges_r[EW-1:0]),
    .wdata({in_item.src_vertex, in_item.dst_vertex}),
    .raddr(ctl.eaddr), .rdata(e_rd));

  // degree memory: add steps are rd src, then wr src / rd dst, then wr dst
  logic [2:0] add_r;
  logic d_we;
  logic [VW-1:0] d_wa, d_ra;
  logic [PW-1:0] d_wd, d_rd;
  always_comb begin
    d_we = 1'b0;
    d_wa = ctl.vaddr;
    d_wd = '0;
    d_ra = ctl.vaddr;
    if (ctl.clr_deg) begin
      d_we = 1'b1;
    end else if (add_r[1]) begin
      d_we = 1'b1;
      d_wa = itm_r.src_vertex;
      d_wd = d_rd + 1'b1;
      d_ra = itm_r.dst_vertex;
    end else if (add_r[2]) begin
      d_we = 1'b1;
      d_wa = itm_r.dst_vertex;
      d_wd = (itm_r.src_vertex == itm_r.dst_vertex) ? d_rd + 2'd2 : d_rd + 1'b1;
    end else if (add_r[0]) begin
      d_ra = itm_r.src_vertex;
    end
  end
  ucsr_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_deg (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));

  // pointer memory (final start offsets) and fill memory (running slot)
  logic scan_d_r;
  logic [VW-1:0] scan_a_r;
  logic p_we, f_we;
  logic [VW-1:0] p_wa, f_wa, f_ra, p_ra;
  logic [PW-1:0] p_wd, f_wd, p_rd, f_rd;
  logic [1:0] sc_r;
  logic [VW-1:0] sa_r, sb_r;
  logic [AW-1:0] adj_wa;
  logic [2*VW-1:0] adj_wd;
  logic adj_we;
  logic [2*VW-1:0] adj_rd;
  logic fwd_r;
  logic [PW-1:0] fwd_d_r;
  logic [PW-1:0] f_cur;

  assign p_we = scan_d_r;
  assign p_wa = scan_a_r;
  assign p_wd = run_r;
  assign p_ra = itm_r.read_index[VW-1:0];

  // back-to-back updates of one vertex: take the value written last cycle
  assign f_cur = fwd_r ? fwd_d_r : f_rd;

  always_comb begin
    f_we = scan_d_r;
    f_wa = scan_a_r;
    f_wd = run_r;
    f_ra = ctl.sub ? e_rd[VW-1:0] : e_rd[2*VW-1:VW];
    if (sc_r[1]) begin
      f_we = 1'b1;
      f_wa = sa_r;
      f_wd = f_cur + 1'b1;
    end
  end
  ucsr_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_ptr (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  ucsr_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_fill (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  assign adj_we = sc_r[1] && f_cur < PW'(2*MAX_EDGES);
  assign adj_wa = f_cur[AW-1:0];
  assign adj_wd = {sa_r, sb_r};
  ucsr_ram #(.WIDTH(2*VW), .DEPTH(2*MAX_EDGES)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(itm_r.read_index), .rdata(adj_rd));

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      itm_r <= in_item;
    end
    scan_a_r <= ctl.vaddr;
    sa_r <= ctl.sub ? e_rd[VW-1:0] : e_rd[2*VW-1:VW];
    sb_r <= ctl.sub ? e_rd[2*VW-1:VW] : e_rd[VW-1:0];
    fwd_r <= f_we && (f_wa == f_ra);
    fwd_d_r <= f_wd;
    if (!rst_n) begin
      edges_r <= '0;
      hi_r <= '0;
      built_r <= 1'b0;
      add_r <= '0;
      scan_d_r <= 1'b0;
      sc_r <= '0;
      rsp_r <= '0;
      run_r <= '0;
      out_valid <= 1'b0;
    end else begin
      add_r <= {add_r[1:0], e_we};
      scan_d_r <= ctl.scan;
      sc_r <= {sc_r[0], ctl.scat};
      if (ctl.scan) begin
        run_r <= (scan_d_r ? run_r + d_rd : '0);
      end
      if (scan_d_r && !ctl.scan) begin
        run_r <= run_r + d_rd;
      end
      if (e_we) begin
        edges_r <= edges_r + 1'b1;
        built_r <= 1'b0;
        if (in_item.src_vertex > hi_r || in_item.dst_vertex > hi_r) begin
          hi_r <= (in_item.src_vertex > in_item.dst_vertex)
                ? in_item.src_vertex : in_item.dst_vertex;
        end
      end
      if (ctl.finish) begin
        built_r <= 1'b1;
      end
      rsp_r <= {rsp_r[0], ctl.respond};
      out_valid <= rsp_r[1] || ctl.finish;
    end
  end

  // response path: item latched at accept, memory read next cycle
  always_ff @(posedge clk) begin
    rd_cmd_r <= itm_r.command;
    endptr_r <= {edges_r, 1'b0};
    if (itm_r.command == CMD_ADD) begin
      if (edges_r == (EW+1)'(MAX_EDGES) && !add_r[1]) begin
        st_r <= ST_FULL;
      end else begin
        st_r <= ST_OK;
      end
    end else if (itm_r.command == CMD_RDPTR) begin
      st_r <= (!built_r || {1'b0, itm_r.read_index} > {3'b0, nv}) ? ST_INDEX : ST_OK;
    end else if (itm_r.command == CMD_RDADJ) begin
      st_r <= (!built_r || {1'b0, itm_r.read_index} >= {edges_r, 1'b0})
            ? ST_INDEX : ST_OK;
    end else begin
      st_r <= ST_OK;
    end
  end

  logic ptr_end;
  assign ptr_end = {1'b0, itm_r.read_index} == {3'b0, nv};
  always_comb begin
    out_item = '0;
    out_item.vertex_count = nv;
    out_item.entry_count = {edges_r, 1'b0};
    out_item.status = st_r;
    if (st_r == ST_OK && rd_cmd_r == CMD_RDPTR) begin
      out_item.pointer_value = ptr_end ? endptr_r : p_rd;
    end
    if (st_r == ST_OK && rd_cmd_r == CMD_RDADJ) begin
      out_item.entry_src = adj_rd[2*VW-1:VW];
      out_item.entry_dst = adj_rd[VW-1:0];
    end
  end
endmodule

FILE: rtl/ucsr_ctrl.sv
// Controller: sequences clear, add, read and build phases.
module ucsr_ctrl import ucsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic [1:0] cmd,
  input  sts_t     sts,
  output logic     busy,
  output ctl_t     ctl
);
  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_WAIT = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_SCAT = 7'b0010000,
    S_DRN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [VW:0] cnt_r, cnt_nxt;
  logic [EW:0] ecnt_r, ecnt_nxt;
  logic sub_r, sub_nxt;
  logic [1:0] wt_r, wt_nxt;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    ecnt_nxt = ecnt_r;
    sub_nxt = sub_r;
    wt_nxt = wt_r;
    ctl = '0;
    ctl.vaddr = cnt_r[VW-1:0];
    ctl.eaddr = ecnt_r[EW-1:0];
    ctl.sub = sub_r;
    busy = 1'b1;
    case (st_r)
      S_CLR: begin
        ctl.clr_deg = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (VW+1)'(MAX_VERTICES - 1)) begin
          st_nxt = S_IDLE;
          cnt_nxt = '0;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          if (cmd == CMD_BUILD) begin
            st_nxt = S_SCAN;
            cnt_nxt = '0;
          end else begin
            ctl.respond = 1'b1;
            st_nxt = S_WAIT;
            wt_nxt = 2'd2;
          end
        end
      end
      S_WAIT: begin
        wt_nxt = wt_r - 1'b1;
        if (wt_r == 2'd1) begin
          st_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cnt_r == sts.nverts) begin
          st_nxt = S_SCAT;
          ecnt_nxt = '0;
          sub_nxt = 1'b0;
        end else begin
          ctl.scan = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAT: begin
        if (ecnt_r == sts.edges) begin
          st_nxt = S_DRN;
          wt_nxt = 2'd3;
        end else begin
          ctl.scat = 1'b1;
          sub_nxt = !sub_r;
          if (sub_r) begin
            ecnt_nxt = ecnt_r + 1'b1;
          end
        end
      end
      S_DRN: begin
        wt_nxt = wt_r - 1'b1;
        if (wt_r == 2'd1) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= '0;
      ecnt_r <= '0;
      sub_r <= 1'b0;
      wt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ecnt_r <= ecnt_nxt;
      sub_r <= sub_nxt;
      wt_r <= wt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctl.accept) else $error("accept while busy");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan |-> cnt_r < sts.nverts) else $error("scan past vertices");
  a_scat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scat |-> ecnt_r < sts.edges) else $error("scatter past edges");
`endif
endmodule

FILE: rtl/undirected_csr_builder.sv
// Top level of the undirected CSR builder.
// After reset the block clears its degree memory with busy high. An add runs one
// degree-memory read-modify-write sequence and a read runs one memory read; each
// result strobes out_valid for one cycle and cannot be stalled.
// During a build busy stays high for the prefix sum over the V vertices, the issue
// of one fill-pointer update per edge end, the drain of the scatter pipeline and
// the posting of the result.
module undirected_csr_builder import ucsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  ctl_t ctl;
  sts_t sts;
  ucsr_ctrl u_ctrl (.clk, .rst_n, .start, .cmd(in_item.command), .sts, .busy, .ctl);
  ucsr_dp u_dp (.clk, .rst_n, .in_item, .ctl, .sts, .out_valid, .out_item);
endmodule
